>>> rtl/ccle_pkg.sv
`default_nettype none

package ccle_pkg;

    // Default vector capacity, in samples per vector.
    localparam int MAX_LEN_DEF = 1024;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int LAG_W    = 11;
    localparam int PEAK_W   = 42;
    localparam int STATUS_W = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DW   = 2 * SAMPLE_W;
    localparam int IN_UW   = 2;
    localparam int OUT_DW  = ((LAG_W + PEAK_W + 7) / 8) * 8;
    localparam int OUT_UW  = STATUS_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    // Tag that rides along with each multiply-accumulate slot.
    typedef struct packed {
        logic vld;    // slot carries work
        logic first;  // first term of a lag: restart the accumulator
        logic last;   // last term of a lag: compare against the best
        logic zero;   // lag has no overlap: term counts as zero
    } t_tag;

endpackage

`default_nettype wire

>>> rtl/cross_correlation_lag_estimator_core.sv
`default_nettype none

// Cross-correlation lag estimator. Samples of two signed 16-bit vectors x and
// y stream in one beat per cycle; each beat may carry a sample of either
// vector (tuser bit 0 / bit 1 mark them present) and present samples are
// appended in arrival order, up to MAX_LEN per vector (extras are dropped and
// flagged). The beat with tlast ends the load. The core then walks every lag
// k = -(L-1) .. L-1 (L = longer length) and sums x[n+k]*y[n] exactly through
// one shared 16x16 multiplier and accumulator, keeping the first maximum. One
// result beat follows: lag, peak value and status (0 ok, 1 both vectors
// empty, 2 samples dropped). Rate: loading is one beat per clock; after tlast
// the input stalls while the core works: a start state, then per lag a setup
// state and one slot per overlapping sample pair (a single zero slot for a lag
// with no overlap), then a drain until the pipeline is empty and the result
// state. With both vectors empty the core goes from start to the result. The
// terms run one after another through the multiplier and RAM read ports.
// A finished result sits in the output register, so the next load may start
// before it is taken; a result still waiting there holds the core in its
// result cycle until the register frees up.
module cross_correlation_lag_estimator_core #(
    parameter int MAX_LEN = ccle_pkg::MAX_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [ccle_pkg::IN_DW-1:0]    i_s_axis_tdata,  // x_sample, y_sample
    input  wire logic [ccle_pkg::IN_UW-1:0]    i_s_axis_tuser,  // x_present, y_present
    input  wire logic                          i_s_axis_tlast,  // last
    // master side
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [ccle_pkg::OUT_DW-1:0]        o_m_axis_tdata,  // lag, peak, zero pad
    output logic [ccle_pkg::OUT_UW-1:0]        o_m_axis_tuser   // status
);

    localparam int SW_ = ccle_pkg::SAMPLE_W;
    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int KW  = CW + 1;
    localparam int SW  = CW + 2;
    localparam int ACC_W = ccle_pkg::PROD_W + $clog2(MAX_LEN);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SETUP,
        S_ISSUE,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_xcnt;
    logic [CW-1:0]         r_ycnt;
    logic                  r_ovf;
    logic signed [KW-1:0]  r_k;
    logic signed [KW-1:0]  r_kmax;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_nhi;
    logic                  r_zero;
    logic                  r_first;
    logic                  r_out_vld;
    logic [ccle_pkg::OUT_DW-1:0]   r_out_data;
    logic [ccle_pkg::OUT_UW-1:0]   r_out_user;

    // input beat decode
    logic                  w_accept;
    logic [SW_-1:0]        w_xs;
    logic [SW_-1:0]        w_ys;
    logic                  w_xp;
    logic                  w_yp;
    logic                  w_xroom;
    logic                  w_yroom;
    logic                  w_xwe;
    logic                  w_ywe;

    // lag setup
    logic [CW-1:0]         w_len;
    logic signed [SW-1:0]  w_k_s;
    logic signed [SW-1:0]  w_nlo;
    logic signed [SW-1:0]  w_yh;
    logic signed [SW-1:0]  w_xh;
    logic signed [SW-1:0]  w_nhi;

    // issue slot
    logic signed [KW-1:0]  w_xi;
    logic                  w_slot_last;
    ccle_pkg::t_tag        w_tag;
    logic                  w_clr;
    logic                  w_out_free;

    // datapath
    logic [SW_-1:0]        w_xrd;
    logic [SW_-1:0]        w_yrd;
    logic                  w_busy;
    logic signed [ACC_W-1:0] w_best;
    logic signed [KW-1:0]  w_best_lag;
    logic [ccle_pkg::STATUS_W-1:0] w_status;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_xs     = i_s_axis_tdata[SW_-1:0];
    assign w_ys     = i_s_axis_tdata[2*SW_-1:SW_];
    assign w_xp     = i_s_axis_tuser[0];
    assign w_yp     = i_s_axis_tuser[1];
    assign w_xroom  = r_xcnt < CW'(MAX_LEN);
    assign w_yroom  = r_ycnt < CW'(MAX_LEN);
    assign w_xwe    = w_accept && w_xp && w_xroom;
    assign w_ywe    = w_accept && w_yp && w_yroom;

    // Overlap range of lag k: n from max(0,-k) to min(Ny-1, Nx-1-k).
    assign w_len  = (r_xcnt > r_ycnt) ? r_xcnt : r_ycnt;
    assign w_k_s  = SW'(r_k);
    assign w_nlo  = r_k[KW-1] ? -w_k_s : SW'(0);
    assign w_yh   = $signed({2'b00, r_ycnt}) - SW'(1);
    assign w_xh   = $signed({2'b00, r_xcnt}) - SW'(1) - w_k_s;
    assign w_nhi  = (w_yh < w_xh) ? w_yh : w_xh;

    assign w_xi        = $signed({1'b0, r_n}) + r_k;
    assign w_slot_last = r_zero || (r_n == r_nhi);
    assign w_tag.vld   = (r_state == S_ISSUE);
    assign w_tag.first = r_first;
    assign w_tag.last  = w_slot_last;
    assign w_tag.zero  = r_zero;

    assign w_clr      = (r_state == S_START);
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    assign w_status = (r_xcnt == '0 && r_ycnt == '0) ? ccle_pkg::ST_EMPTY :
                      r_ovf                          ? ccle_pkg::ST_DROP  :
                                                       ccle_pkg::ST_OK;

    ccle_ram #(
        .WIDTH (SW_),
        .DEPTH (MAX_LEN)
    ) u_xram (
        .i_clk   (i_clk),
        .i_we    (w_xwe),
        .i_waddr (r_xcnt[AW-1:0]),
        .i_wdata (w_xs),
        .i_raddr (w_xi[AW-1:0]),
        .o_rdata (w_xrd)
    );

    ccle_ram #(
        .WIDTH (SW_),
        .DEPTH (MAX_LEN)
    ) u_yram (
        .i_clk   (i_clk),
        .i_we    (w_ywe),
        .i_waddr (r_ycnt[AW-1:0]),
        .i_wdata (w_ys),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (w_yrd)
    );

    ccle_mac #(
        .MAX_LEN (MAX_LEN)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (w_clr),
        .i_tag      (w_tag),
        .i_k        (r_k),
        .i_x        ($signed(w_xrd)),
        .i_y        ($signed(w_yrd)),
        .o_busy     (w_busy),
        .o_best     (w_best),
        .o_best_lag (w_best_lag)
    );

    // Sequencer: load, then per lag a setup state and one slot per term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_xcnt    <= '0;
            r_ycnt    <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // the result cycle reloads the output register itself
            if (r_out_vld && i_m_axis_tready && (r_state != S_FINISH)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_xwe) begin
                            r_xcnt <= r_xcnt + CW'(1);
                        end
                        if (w_ywe) begin
                            r_ycnt <= r_ycnt + CW'(1);
                        end
                        if ((w_xp && !w_xroom) || (w_yp && !w_yroom)) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_kmax <= $signed({1'b0, w_len}) - KW'(1);
                    r_k    <= KW'(1) - $signed({1'b0, w_len});
                    if (r_xcnt == '0 && r_ycnt == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_n     <= w_nlo[CW-1:0];
                    r_nhi   <= w_nhi[CW-1:0];
                    r_zero  <= w_nhi < w_nlo;
                    r_first <= 1'b1;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_first <= 1'b0;
                    if (w_slot_last) begin
                        if (r_k == r_kmax) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_SETUP;
                        end
                    end else begin
                        r_n <= r_n + CW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= ccle_pkg::OUT_DW'({
                            ccle_pkg::PEAK_W'(w_best),
                            ccle_pkg::LAG_W'(w_best_lag)});
                        r_out_user <= w_status;
                        r_xcnt     <= '0;
                        r_ycnt     <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Loading never overlaps pipeline work.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !w_busy)
        else $error("pipeline busy during load");

    // Counts saturate at capacity.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xcnt <= CW'(MAX_LEN)) && (r_ycnt <= CW'(MAX_LEN)))
        else $error("sample count past capacity");

    // Every real term reads inside both loaded vectors.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE && !r_zero) |->
            (w_xi >= 0) && (w_xi < $signed({1'b0, r_xcnt})) && (r_n < r_ycnt))
        else $error("term read outside loaded samples");

    // Delivering a result restarts the load with empty vectors.
    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=>
            (r_xcnt == '0) && (r_ycnt == '0) && !r_ovf && r_out_vld)
        else $error("result not posted or counts not cleared");

endmodule

`default_nettype wire

>>> rtl/ccle_ram.sv
`default_nettype none

module ccle_ram #(
    parameter int WIDTH = ccle_pkg::SAMPLE_W,
    parameter int DEPTH = ccle_pkg::MAX_LEN_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/ccle_mac.sv
`default_nettype none

// Shared multiply-accumulate-compare unit. Tag and lag enter with the RAM
// read address; the RAM read is registered, so its data lines up with stage 1.
module ccle_mac #(
    parameter int MAX_LEN = ccle_pkg::MAX_LEN_DEF,
    localparam int CW    = $clog2(MAX_LEN + 1),
    localparam int KW    = CW + 1,
    localparam int ACC_W = ccle_pkg::PROD_W + $clog2(MAX_LEN)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_clr,
    input  wire ccle_pkg::t_tag                      i_tag,
    input  wire logic signed [KW-1:0]                i_k,
    input  wire logic signed [ccle_pkg::SAMPLE_W-1:0] i_x,
    input  wire logic signed [ccle_pkg::SAMPLE_W-1:0] i_y,
    output logic                                     o_busy,
    output logic signed [ACC_W-1:0]                  o_best,
    output logic signed [KW-1:0]                     o_best_lag
);

    ccle_pkg::t_tag                      r_s1;
    ccle_pkg::t_tag                      r_s2;
    logic signed [KW-1:0]                r_k1;
    logic signed [KW-1:0]                r_k2;
    logic signed [ccle_pkg::PROD_W-1:0]  r_prod;
    logic signed [ccle_pkg::PROD_W-1:0]  w_mult;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [ACC_W-1:0]             w_sum;
    logic signed [ACC_W-1:0]             r_best;
    logic signed [KW-1:0]                r_best_lag;
    logic                                r_have;

    assign w_mult = i_x * i_y;
    assign w_sum  = (r_s2.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_s2   <= '0;
            r_have <= 1'b0;
        end else begin
            r_s1 <= i_tag;
            r_s2 <= r_s1;
            if (i_clr) begin
                r_have <= 1'b0;
            end else if (r_s2.vld && r_s2.last) begin
                r_have <= 1'b1;
            end
        end
        r_k1 <= i_k;
        r_k2 <= r_k1;
        if (r_s1.vld) begin
            r_prod <= r_s1.zero ? ccle_pkg::PROD_W'(0) : w_mult;
        end
        if (r_s2.vld) begin
            r_acc <= w_sum;
        end
        if (i_clr) begin
            r_best     <= '0;
            r_best_lag <= '0;
        end else if (r_s2.vld && r_s2.last && (!r_have || w_sum > r_best)) begin
            r_best     <= w_sum;
            r_best_lag <= r_k2;
        end
    end

    assign o_busy     = r_s1.vld || r_s2.vld;
    assign o_best     = r_best;
    assign o_best_lag = r_best_lag;

endmodule

`default_nettype wire
